@@ hdl/bob_pkg.sv @@
// ----------------------------------------------------------------------------
// bob_pkg
// Shared types and constants of the bucket occupancy bitmap.
// ----------------------------------------------------------------------------
package bob_pkg;

  localparam int WORDS_DEF     = 32;
  localparam int WORD_BITS_DEF = 128;
  localparam int CHUNK_BITS    = 64;
  localparam int POS_W         = 6;
  localparam int INDEX_W       = 12;
  localparam int CHUNK_IDX_W   = INDEX_W - POS_W;
  localparam int WC_W          = 6;
  localparam logic [WC_W-1:0] WC_RESET = 6'd32;

  typedef enum logic [2:0] {
    CMD_SET       = 3'd0,
    CMD_CLEAR     = 3'd1,
    CMD_TEST      = 3'd2,
    CMD_FIND      = 3'd3,
    CMD_CLEAR_ALL = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [INDEX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic               bit_value;
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic               index_error;
  } res_t;

  typedef struct packed {
    logic                   wr_en;
    logic                   clear_all;
    logic [CHUNK_IDX_W-1:0] wr_chunk;
    logic [CHUNK_IDX_W-1:0] rd_chunk;
  } store_ctrl_t;

endpackage

@@ hdl/bob_ffs.sv @@
// ----------------------------------------------------------------------------
// bob_ffs
// Finds the lowest set bit of one 64-bit chunk by six halving steps.
// ----------------------------------------------------------------------------
module bob_ffs (
  input  logic [bob_pkg::CHUNK_BITS-1:0] vec_i,
  output logic                           any_o,
  output logic [bob_pkg::POS_W-1:0]      pos_o
);

  always_comb begin
    logic [bob_pkg::CHUNK_BITS-1:0] v;
    logic [bob_pkg::CHUNK_BITS-1:0] low_mask;
    v     = vec_i;
    pos_o = '0;
    for (int k = bob_pkg::POS_W - 1; k >= 0; k--) begin
      low_mask = (bob_pkg::CHUNK_BITS'(1) << (1 << k)) - bob_pkg::CHUNK_BITS'(1);
      if ((v & low_mask) == '0) begin
        pos_o[k] = 1'b1;
        v        = v >> (1 << k);
      end
    end
    any_o = (vec_i != '0);
  end

endmodule

@@ hdl/bob_store.sv @@
// ----------------------------------------------------------------------------
// bob_store
// Chunk memory of the bitmap with a valid bit per chunk, so that clearing the
// whole map is a single write of the valid bits. The read data is registered.
// ----------------------------------------------------------------------------
module bob_store #(
  parameter int DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bob_pkg::store_ctrl_t           ctrl_i,
  input  logic [bob_pkg::CHUNK_BITS-1:0] wr_data_i,
  output logic [bob_pkg::CHUNK_BITS-1:0] rd_data_o
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bob_pkg::CHUNK_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]               valid_q;
  logic [bob_pkg::CHUNK_BITS-1:0] rd_q;
  logic                           rd_valid_q;
  logic [ADDR_W-1:0]              wr_addr;
  logic [ADDR_W-1:0]              rd_addr;

  assign wr_addr = ADDR_W'(ctrl_i.wr_chunk);
  assign rd_addr = ADDR_W'(ctrl_i.rd_chunk);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr] <= wr_data_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr];
      if (ctrl_i.clear_all) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

@@ hdl/bucket_occupancy_bitmap.sv @@
// ----------------------------------------------------------------------------
// bucket_occupancy_bitmap
// Occupancy bitmap of a bucket priority queue: set, clear and test one bit,
// clear the map, or find the lowest set bucket at or above a start index.
// ----------------------------------------------------------------------------
// Set, clear and test read the chunk, then set and clear write it back modified.
// A find visits the 64-bit chunks one per cycle through the single first-set
// unit and the single memory read port.
// Clear all, refused indices and unused commands are answered from idle.
// The result strobe follows the cycle that decides it; the receiver cannot stall.
// Reset clears the map at once through per-chunk valid bits; word count is 32.
module bucket_occupancy_bitmap #(
  parameter int WORDS     = bob_pkg::WORDS_DEF,
  parameter int WORD_BITS = bob_pkg::WORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  bob_pkg::cmd_t            cmd_i,
  output logic                     res_strobe_o,
  output bob_pkg::res_t            res_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bob_pkg::WC_W-1:0] cfg_data_i
);

  localparam int CHUNKS    = (WORDS * WORD_BITS + bob_pkg::CHUNK_BITS - 1) /
                             bob_pkg::CHUNK_BITS;
  localparam int MAX_CHUNK = 1 << bob_pkg::CHUNK_IDX_W;
  localparam int DEPTH     = (CHUNKS < MAX_CHUNK) ? CHUNKS : MAX_CHUNK;
  localparam int LIM_RAW   = $clog2(WORDS * WORD_BITS + 1);
  localparam int LIM_W     = (LIM_RAW > bob_pkg::INDEX_W + 1) ? LIM_RAW
                                                              : bob_pkg::INDEX_W + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                           state_q, state_d;
  logic [2:0]                       cmd_q, cmd_d;
  logic [bob_pkg::INDEX_W-1:0]      idx_q, idx_d;
  logic [bob_pkg::CHUNK_IDX_W-1:0]  chunk_q, chunk_d;
  logic [bob_pkg::POS_W-1:0]        low_q, low_d;
  logic [bob_pkg::WC_W-1:0]         wc_q;
  logic                             strobe_q, strobe_d;
  bob_pkg::res_t                    res_q, res_d;

  logic [LIM_W-1:0]                 wc_ext;
  logic [LIM_W-1:0]                 wc_sat;
  logic [LIM_W-1:0]                 limit;
  logic                             in_err;
  logic [bob_pkg::CHUNK_BITS-1:0]   rd_data;
  logic [bob_pkg::CHUNK_BITS-1:0]   wr_data;
  logic [bob_pkg::CHUNK_BITS-1:0]   bit_mask;
  logic [bob_pkg::CHUNK_BITS-1:0]   ffs_in;
  logic                             ffs_any;
  logic [bob_pkg::POS_W-1:0]        ffs_pos;
  logic [bob_pkg::CHUNK_IDX_W:0]    next_chunk;
  logic [bob_pkg::INDEX_W-1:0]      hit;
  bob_pkg::store_ctrl_t             st_ctrl;

  assign wc_ext = LIM_W'(wc_q);
  assign wc_sat = (wc_ext > LIM_W'(WORDS)) ? LIM_W'(WORDS) : wc_ext;
  assign limit  = LIM_W'(wc_sat * LIM_W'(WORD_BITS));
  assign in_err = (LIM_W'(cmd_i.index) >= limit);

  assign busy        = (state_q == S_EXEC);
  assign cfg_ready_o = 1'b1;

  assign bit_mask   = bob_pkg::CHUNK_BITS'(1) << idx_q[bob_pkg::POS_W-1:0];
  assign ffs_in     = rd_data & ({bob_pkg::CHUNK_BITS{1'b1}} << low_q);
  assign next_chunk = {1'b0, chunk_q} + 1'b1;
  assign hit        = {chunk_q, ffs_pos};

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    chunk_d   = chunk_q;
    low_d     = low_q;
    strobe_d  = 1'b0;
    res_d     = '0;
    wr_data   = rd_data;
    st_ctrl   = '0;
    st_ctrl.wr_chunk = chunk_q;
    st_ctrl.rd_chunk = chunk_q;
    unique case (state_q)
      S_IDLE: begin
        st_ctrl.rd_chunk = cmd_i.index[bob_pkg::INDEX_W-1:bob_pkg::POS_W];
        if (start) begin
          cmd_d   = cmd_i.command;
          idx_d   = cmd_i.index;
          chunk_d = cmd_i.index[bob_pkg::INDEX_W-1:bob_pkg::POS_W];
          low_d   = cmd_i.index[bob_pkg::POS_W-1:0];
          case (cmd_i.command)
            bob_pkg::CMD_SET, bob_pkg::CMD_CLEAR, bob_pkg::CMD_TEST,
            bob_pkg::CMD_FIND: begin
              if (in_err) begin
                strobe_d          = 1'b1;
                res_d.index_error = 1'b1;
              end else begin
                state_d = S_EXEC;
              end
            end
            bob_pkg::CMD_CLEAR_ALL: begin
              st_ctrl.clear_all = 1'b1;
              strobe_d          = 1'b1;
            end
            default: begin
              strobe_d = 1'b1;
            end
          endcase
        end
      end
      S_EXEC: begin
        case (cmd_q)
          bob_pkg::CMD_SET: begin
            wr_data       = rd_data | bit_mask;
            st_ctrl.wr_en = 1'b1;
            strobe_d      = 1'b1;
            state_d       = S_IDLE;
          end
          bob_pkg::CMD_CLEAR: begin
            wr_data       = rd_data & ~bit_mask;
            st_ctrl.wr_en = 1'b1;
            strobe_d      = 1'b1;
            state_d       = S_IDLE;
          end
          bob_pkg::CMD_TEST: begin
            res_d.bit_value = ((rd_data & bit_mask) != '0);
            strobe_d        = 1'b1;
            state_d         = S_IDLE;
          end
          default: begin
            if (ffs_any) begin
              if (LIM_W'(hit) < limit) begin
                res_d.found       = 1'b1;
                res_d.found_index = hit;
              end
              strobe_d = 1'b1;
              state_d  = S_IDLE;
            end else if (next_chunk[bob_pkg::CHUNK_IDX_W] ||
                         (LIM_W'({next_chunk, {bob_pkg::POS_W{1'b0}}}) >= limit)) begin
              strobe_d = 1'b1;
              state_d  = S_IDLE;
            end else begin
              chunk_d          = next_chunk[bob_pkg::CHUNK_IDX_W-1:0];
              low_d            = '0;
              st_ctrl.rd_chunk = next_chunk[bob_pkg::CHUNK_IDX_W-1:0];
            end
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
      wc_q     <= bob_pkg::WC_RESET;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        wc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    chunk_q <= chunk_d;
    low_q   <= low_d;
    res_q   <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  bob_ffs u_ffs (
    .vec_i (ffs_in),
    .any_o (ffs_any),
    .pos_o (ffs_pos)
  );

  bob_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (st_ctrl),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

endmodule

@@ tb/sv/occupancy_checker.sv @@
// ----------------------------------------------------------------------------
// occupancy_checker
// Watches the command, result and word count channels of the bucket
// occupancy bitmap. It keeps its own copy of the bitmap and the word count,
// works out the expected result of every accepted command and compares each
// result word, field by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module occupancy_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic                     busy,
  input  bob_pkg::cmd_t            cmd_i,
  input  logic                     res_strobe_o,
  input  bob_pkg::res_t            res_o,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_o,
  input  logic [bob_pkg::WC_W-1:0] cfg_data_i,
  output int                       fail_cnt_o,
  output int                       pending_o,
  output int                       checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BITS = bob_pkg::WORDS_DEF * bob_pkg::WORD_BITS_DEF;

  bit [TOTAL_BITS-1:0]      occupancy;
  logic [bob_pkg::WC_W-1:0] word_count;
  bob_pkg::res_t            expected_results[$];
  int                       fails;
  int                       outstanding;
  int                       checked;

  assign fail_cnt_o = fails;
  assign pending_o  = outstanding;
  assign checked_o  = checked;

  function automatic int range_in_use();
    int words;
    words = (word_count > bob_pkg::WORDS_DEF) ? bob_pkg::WORDS_DEF : int'(word_count);
    return words * bob_pkg::WORD_BITS_DEF;
  endfunction

  // Applies one command to the local bitmap and returns the result word that
  // the block must produce for it.
  function automatic bob_pkg::res_t predict_occupancy(bob_pkg::cmd_t c);
    bob_pkg::res_t r;
    int            lim;
    int            idx;
    r   = '0;
    lim = range_in_use();
    idx = int'(c.index);
    case (c.command)
      bob_pkg::CMD_CLEAR_ALL: begin
        occupancy = '0;
      end
      bob_pkg::CMD_SET, bob_pkg::CMD_CLEAR, bob_pkg::CMD_TEST, bob_pkg::CMD_FIND: begin
        if (idx >= lim) begin
          r.index_error = 1'b1;
        end else if (c.command == bob_pkg::CMD_SET) begin
          occupancy[idx] = 1'b1;
        end else if (c.command == bob_pkg::CMD_CLEAR) begin
          occupancy[idx] = 1'b0;
        end else if (c.command == bob_pkg::CMD_TEST) begin
          r.bit_value = occupancy[idx];
        end else begin
          for (int p = idx; p < lim; p++) begin
            if (occupancy[p]) begin
              r.found       = 1'b1;
              r.found_index = bob_pkg::INDEX_W'(p);
              break;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  initial begin
    fails   = 0;
    checked = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bob_pkg::res_t want;
    if (!rst_ni) begin
      occupancy   = '0;
      word_count  = bob_pkg::WC_RESET;
      outstanding = 0;
      expected_results.delete();
    end else begin
      if (res_strobe_o) begin
        if (expected_results.size() == 0) begin
          $error("result word with no command outstanding");
          fails++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (res_o.bit_value !== want.bit_value) begin
            $error("bit_value: expected %0d, got %0d", want.bit_value, res_o.bit_value);
            fails++;
          end
          if (res_o.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, res_o.found);
            fails++;
          end
          if (res_o.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index,
                   res_o.found_index);
            fails++;
          end
          if (res_o.index_error !== want.index_error) begin
            $error("index_error: expected %0d, got %0d", want.index_error,
                   res_o.index_error);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_occupancy(cmd_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        word_count = cfg_data_i;
      end
      outstanding = expected_results.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the bucket occupancy bitmap. A short directed sequence covers
// the edges of the index range, every command and the word count corner
// cases, then random phases at several word counts exercise set, clear, test, find,
// clear all and unused codes against a checker that predicts every result word.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 100;
  localparam int STALL_MAX  = 5000;
  localparam int DRAIN_WAIT = 80;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  bob_pkg::cmd_t            cmd_i;
  logic                     res_strobe_o;
  bob_pkg::res_t            res_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [bob_pkg::WC_W-1:0] cfg_data_i;

  int fail_cnt;
  int pending;
  int checked;
  int sender_idle_pct;
  int issued;
  int wc_writes;
  int stall_cycles;
  int current_wc;

  bucket_occupancy_bitmap u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  occupancy_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || res_strobe_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue(input logic [2:0] command, input int index);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start         <= 1'b1;
    cmd_i.command <= command;
    cmd_i.index   <= bob_pkg::INDEX_W'(index);
    do @(posedge clk_i); while (busy);
    issued++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_word_count(input int value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= bob_pkg::WC_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    current_wc = value;
    wc_writes++;
  endtask

  // Close to half of the indices fall in a narrow window so that tests, clears and finds
  // land on buckets that were set shortly before.
  task automatic issue_random(input int hot);
    int          r;
    int          lim;
    int          index;
    logic [2:0]  command;
    lim = ((current_wc > bob_pkg::WORDS_DEF) ? bob_pkg::WORDS_DEF : current_wc) *
          bob_pkg::WORD_BITS_DEF;
    r   = $urandom_range(99);
    if (r < 30) begin
      command = bob_pkg::CMD_SET;
    end else if (r < 45) begin
      command = bob_pkg::CMD_CLEAR;
    end else if (r < 65) begin
      command = bob_pkg::CMD_TEST;
    end else if (r < 92) begin
      command = bob_pkg::CMD_FIND;
    end else if (r < 95) begin
      command = bob_pkg::CMD_CLEAR_ALL;
    end else begin
      command = 3'(bob_pkg::CMD_CLEAR_ALL + $urandom_range(3, 1));
    end
    r = $urandom_range(99);
    if (r < 10 || lim == 0) begin
      index = $urandom_range(4095);
    end else if (r < 55) begin
      index = (hot + $urandom_range(63)) % lim;
    end else begin
      index = $urandom_range(lim - 1);
    end
    issue(command, index);
  endtask

  initial begin
    int wc_plan[PHASES];
    wc_plan = '{32, 1, 63, 5, 0, 31, 2, 33, 16, 63, 3, 32};
    rst_ni          = 1'b0;
    start           = 1'b0;
    cmd_i           = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    sender_idle_pct = 0;
    issued          = 0;
    wc_writes       = 0;
    stall_cycles    = 0;
    current_wc      = int'(bob_pkg::WC_RESET);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    issue(bob_pkg::CMD_TEST, 0);
    issue(bob_pkg::CMD_FIND, 0);
    issue(bob_pkg::CMD_SET, 0);
    issue(bob_pkg::CMD_SET, 4095);
    issue(bob_pkg::CMD_SET, 127);
    issue(bob_pkg::CMD_SET, 128);
    issue(bob_pkg::CMD_TEST, 4095);
    issue(bob_pkg::CMD_TEST, 1);
    issue(bob_pkg::CMD_FIND, 1);
    issue(bob_pkg::CMD_FIND, 129);
    issue(bob_pkg::CMD_FIND, 4095);
    issue(bob_pkg::CMD_CLEAR, 4095);
    issue(bob_pkg::CMD_FIND, 129);
    issue(3'(bob_pkg::CMD_CLEAR_ALL + 1), 4095);
    issue(3'(bob_pkg::CMD_CLEAR_ALL + 3), 0);
    issue(bob_pkg::CMD_CLEAR_ALL, 4095);
    issue(bob_pkg::CMD_FIND, 0);
    issue(bob_pkg::CMD_SET, 200);
    write_word_count(1);
    issue(bob_pkg::CMD_FIND, 0);
    issue(bob_pkg::CMD_SET, 128);
    issue(bob_pkg::CMD_SET, 127);
    issue(bob_pkg::CMD_FIND, 0);
    write_word_count(0);
    issue(bob_pkg::CMD_TEST, 0);
    issue(bob_pkg::CMD_FIND, 0);
    write_word_count(63);
    issue(bob_pkg::CMD_SET, 4095);
    issue(bob_pkg::CMD_FIND, 201);

    for (int ph = 0; ph < PHASES; ph++) begin
      int hot;
      write_word_count(wc_plan[ph]);
      sender_idle_pct = (ph < PHASES / 3) ? 23 : (ph < 2 * PHASES / 3) ? 53 : 0;
      hot = $urandom_range(4095);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if ($urandom_range(31) == 0) begin
          hot = $urandom_range(4095);
        end
        issue_random(hot);
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Issued %0d commands under %0d word count writes, from empty to full range.",
             issued, wc_writes);
    $display("Compared %0d result words against the predicted bitmap.", checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/bob_pkg.sv
hdl/bob_ffs.sv
hdl/bob_store.sv
hdl/bucket_occupancy_bitmap.sv
tb/sv/occupancy_checker.sv
tb/sv/tb_top.sv
